// File: hdl/bba_pkg.sv
package bba_pkg;

    localparam int NUM_CHUNKS_DEF = 16;
    localparam int CHUNK_WORDS_DEF = 256;
    localparam int MAP_BITS = 32;

    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_FREED = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [8:0] request_words;
        logic [3:0] free_chunk;
        logic [7:0] free_offset;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] chunk_index;
        logic [4:0] first_block;
        logic       chunk_added;
        logic       chunk_released;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_NEW,
        S_FREE,
        S_DONE
    } state_t;

    // Command from the sequencer to every cell.
    typedef struct packed {
        logic        take;
        logic        activate;
        logic        free_op;
        logic [31:0] runmask;
        logic [5:0]  nblocks;
        logic [4:0]  blk;
    } cell_cmd_t;

    typedef struct packed {
        logic       active;
        logic       fit;
        logic [4:0] pos;
    } cell_stat_t;

endpackage

// File: hdl/bba_cell.sv
module bba_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  bba_pkg::cell_cmd_t cmd,
    input  logic              sel,
    output bba_pkg::cell_stat_t stat,
    output logic              empty_after
);
    import bba_pkg::*;

    logic        active_reg, active_next;
    logic [31:0] used_reg, used_next;
    logic [31:0] cont_reg, cont_next;
    logic [31:0] clr;
    logic [31:0] m;
    logic        fit;
    logic [4:0]  pos;
    logic        run;

    always_comb
    begin
        fit = 1'b0;
        pos = '0;
        for (int f = MAP_BITS - 1; f >= 0; f--)
        begin
            if ((33 - int'(cmd.nblocks)) > f &&
                ((used_reg & (cmd.runmask << f)) == 32'd0))
            begin
                fit = 1'b1;
                pos = 5'(f);
            end
        end
    end

    assign stat.active = active_reg;
    assign stat.fit = fit & active_reg;
    assign stat.pos = pos;

    always_comb
    begin
        clr = '0;
        clr[cmd.blk] = 1'b1;
        run = 1'b1;
        for (int b = 0; b < MAP_BITS; b++)
        begin
            if (b > int'(cmd.blk))
            begin
                run = run & cont_reg[b];
                clr[b] = run;
            end
        end
    end

    assign empty_after = ((used_reg & ~clr) == 32'd0);

    always_comb
    begin
        active_next = active_reg;
        used_next = used_reg;
        cont_next = cont_reg;
        m = cmd.runmask << pos;
        if (sel && cmd.take)
        begin
            used_next = used_reg | m;
            cont_next = (cont_reg | m) & ~(32'd1 << pos);
        end
        if (sel && cmd.activate)
        begin
            active_next = 1'b1;
            used_next = cmd.runmask;
            cont_next = cmd.runmask & ~32'd1;
        end
        if (sel && cmd.free_op)
        begin
            used_next = used_reg & ~clr;
            cont_next = cont_reg & ~(clr & ~(32'd1 << cmd.blk));
            if (empty_after)
            begin
                active_next = 1'b0;
                used_next = '1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            used_reg <= '1;
            cont_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
            used_reg <= used_next;
            cont_reg <= cont_next;
        end
    end

endmodule

// File: hdl/bitmap_block_allocator_unit.sv
// Channel | Direction | Payload    | Handshake
// in      | input     | in_item_t  | in_valid / in_stall
// out     | output    | out_item_t | out_valid / out_stall
// An allocate visits the chunk cells with the round-robin scan pointer in S_SCAN,
// then activates a new slot in S_NEW if none fits. A free passes through S_FREE,
// and a rejected request goes straight to S_DONE.
// Reset clears all slots to idle and the scan pointer to slot 0.
// A stalled result holds in the output register; a new item is taken once it leaves.
module bitmap_block_allocator_unit
#(
    parameter int NUM_CHUNKS = bba_pkg::NUM_CHUNKS_DEF,
    parameter int CHUNK_WORDS = bba_pkg::CHUNK_WORDS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bba_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output bba_pkg::out_item_t out_data
);
    import bba_pkg::*;

    localparam int CW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int BLK_WORDS = CHUNK_WORDS / 32;
    localparam int BSH = $clog2(BLK_WORDS);

    state_t state_reg, state_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW:0]   cnt_reg, cnt_next;
    logic [CW-1:0] last_reg, last_next;
    logic [5:0]    nb_reg, nb_next;
    logic [4:0]    blk_reg, blk_next;
    logic [CW-1:0] fch_reg, fch_next;
    logic          ov_reg, ov_next;
    out_item_t     od_reg, od_next;

    cell_cmd_t  cmd;
    cell_stat_t stat [NUM_CHUNKS];
    logic       empty [NUM_CHUNKS];
    logic [NUM_CHUNKS-1:0] sel;
    logic [NUM_CHUNKS-1:0] idle_vec;
    logic          idle_any;
    logic [CW-1:0] idle_idx;
    logic [16:0]   wsum;
    logic [16:0]   nbw;
    logic          take_in;

    genvar g;
    generate
        for (g = 0; g < NUM_CHUNKS; g++)
        begin : g_cell
            bba_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .sel         (sel[g]),
                .stat        (stat[g]),
                .empty_after (empty[g])
            );
            assign idle_vec[g] = ~stat[g].active;
        end
    endgenerate

    always_comb
    begin
        idle_any = 1'b0;
        idle_idx = '0;
        for (int i = NUM_CHUNKS - 1; i >= 0; i--)
        begin
            if (idle_vec[i])
            begin
                idle_any = 1'b1;
                idle_idx = CW'(i);
            end
        end
    end

    assign in_stall = (state_reg != S_IDLE) || ov_reg;
    assign take_in = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign out_data = od_reg;
    assign wsum = 17'(in_data.request_words) + 17'(BLK_WORDS - 1);
    assign nbw = wsum >> BSH;

    always_comb
    begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        cnt_next = cnt_reg;
        last_next = last_reg;
        nb_next = nb_reg;
        blk_next = blk_reg;
        fch_next = fch_reg;
        ov_next = ov_reg;
        od_next = od_reg;
        sel = '0;
        cmd = '0;
        cmd.nblocks = nb_reg;
        cmd.runmask = 32'((64'd1 << nb_reg) - 64'd1);
        cmd.blk = blk_reg;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (take_in)
                begin
                    od_next = '0;
                    if (in_data.opcode == OP_ALLOC)
                    begin
                        nb_next = 6'(nbw);
                        ptr_next = last_reg;
                        cnt_next = '0;
                        if (in_data.request_words == 9'd0 || nbw > 17'd32)
                        begin
                            od_next.status = ST_NOSPACE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        blk_next = 5'(in_data.free_offset >> BSH);
                        fch_next = CW'(in_data.free_chunk);
                        if (32'(in_data.free_chunk) >= NUM_CHUNKS ||
                            32'(in_data.free_offset) >= CHUNK_WORDS ||
                            !stat[CW'(in_data.free_chunk)].active)
                        begin
                            od_next.status = ST_IGNORED;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FREE;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == (CW+1)'(NUM_CHUNKS))
                begin
                    state_next = S_NEW;
                end
                else if (stat[ptr_reg].fit)
                begin
                    cmd.take = 1'b1;
                    sel[ptr_reg] = 1'b1;
                    last_next = ptr_reg;
                    od_next.status = ST_ALLOC;
                    od_next.chunk_index = 4'(ptr_reg);
                    od_next.first_block = stat[ptr_reg].pos;
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    ptr_next = (32'(ptr_reg) == NUM_CHUNKS - 1) ? '0 : ptr_reg + 1'b1;
                end
            end
            S_NEW:
            begin
                if (idle_any)
                begin
                    cmd.activate = 1'b1;
                    sel[idle_idx] = 1'b1;
                    last_next = idle_idx;
                    od_next.status = ST_ALLOC;
                    od_next.chunk_index = 4'(idle_idx);
                    od_next.chunk_added = 1'b1;
                end
                else
                begin
                    od_next.status = ST_NOSPACE;
                end
                state_next = S_DONE;
            end
            S_FREE:
            begin
                cmd.free_op = 1'b1;
                sel[fch_reg] = 1'b1;
                od_next.status = ST_FREED;
                od_next.chunk_index = 4'(fch_reg);
                od_next.first_block = blk_reg;
                if (empty[fch_reg])
                begin
                    od_next.chunk_released = 1'b1;
                    if (last_reg == fch_reg)
                    begin
                        last_next = '0;
                    end
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg <= '0;
            cnt_reg <= '0;
            last_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg <= ptr_next;
            cnt_reg <= cnt_next;
            last_reg <= last_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nb_reg <= nb_next;
        blk_reg <= blk_next;
        fch_reg <= fch_next;
        od_reg <= od_next;
    end

endmodule
